[src/rwcc_pkg.sv]
// Package for the random walk coverage counter: widths, direction codes and
// the structs passed between the walk controller and the top level.
// No dependencies.
package rwcc_pkg;

  localparam int DEF_MAX_HALF = 64;  // default largest half size
  localparam int HALF_W       = 7;   // half_size register width
  localparam int CNT_W        = 14;  // count and output field width

  // Step direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // One finished walk
  typedef struct packed {
    logic [CNT_W-1:0] visited;
    logic [CNT_W-1:0] interior;
  } result_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic clearing;   // bitmap clearing pass in progress
    logic finishing;  // result offered, waiting for the output register
  } ctrl_stat_t;

endpackage

[src/rwcc_map_mem.sv]
// Visited bitmap storage: one row per x coordinate, one bit per y coordinate.
// Single write port, single read port with registered read data.
// Depends on nothing outside this file.
module rwcc_map_mem #(
  parameter int ROWS = 129,
  parameter int COLS = 129,
  parameter int AW   = 8
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_row,
  output logic [COLS-1:0] rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_row,
  input  logic [COLS-1:0] wr_data
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

[src/rwcc_walk_ctrl.sv]
// Walk controller: position, distinct count, read-modify-write of the bitmap
// and the clearing pass. Uses rwcc_pkg; drives the ports of rwcc_map_mem.
module rwcc_walk_ctrl
  import rwcc_pkg::*;
#(
  parameter int MAX_HALF = DEF_MAX_HALF,
  parameter int MAP_SIDE = 2 * MAX_HALF + 1,
  parameter int ROW_W    = $clog2(MAP_SIDE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [HALF_W-1:0]   half_size,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          direction,
  output logic                rd_en,
  output logic [ROW_W-1:0]    rd_row,
  input  logic [MAP_SIDE-1:0] rd_data,
  output logic                wr_en,
  output logic [ROW_W-1:0]    wr_row,
  output logic [MAP_SIDE-1:0] wr_data,
  input  logic                res_ready,
  output ctrl_stat_t          stat,
  output result_t             res
);

  localparam int HW    = $clog2(MAX_HALF + 1);
  localparam int POS_W = HW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MARK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [1:0]              state;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [CNT_W-1:0]        count;
  logic [HW-1:0]           h_q;
  logic [HW-1:0]           hmax;
  logic [1:0]              dir_q;
  logic [ROW_W-1:0]        row_q;
  logic [ROW_W-1:0]        col_q;
  logic [ROW_W-1:0]        clr_row;
  logic [ROW_W-1:0]        clr_last;

  logic [HW-1:0]           h_eff;
  logic                    inside_now;
  logic signed [POS_W-1:0] pos_x_next;
  logic signed [POS_W-1:0] pos_y_next;
  logic                    inside_next;
  logic                    seen;
  logic [POS_W-1:0]        row_sum;
  logic [POS_W-1:0]        col_sum;
  logic [HW:0]             side;
  logic [2*HW+1:0]         side_sq;

  function automatic logic interior(input logic signed [POS_W-1:0] px,
                                    input logic signed [POS_W-1:0] py,
                                    input logic [HW-1:0] h);
    logic signed [POS_W-1:0] hp;
    logic signed [POS_W-1:0] hn;
    hp = $signed({1'b0, h});
    hn = -hp;
    return (px < hp) && (px > hn) && (py < hp) && (py > hn);
  endfunction

  // Clamp the register to 1..MAX_HALF
  always_comb begin
    if (half_size == '0) begin
      h_eff = HW'(1);
    end else if (int'(half_size) > MAX_HALF) begin
      h_eff = HW'(MAX_HALF);
    end else begin
      h_eff = HW'(half_size);
    end
  end

  assign inside_now = interior(pos_x, pos_y, h_eff);
  assign row_sum    = POS_W'(pos_x) + POS_W'(MAX_HALF);
  assign col_sum    = POS_W'(pos_y) + POS_W'(MAX_HALF);

  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    case (dir_q)
      DIR_UP:    pos_y_next = pos_y + POS_W'(1);
      DIR_RIGHT: pos_x_next = pos_x + POS_W'(1);
      DIR_DOWN:  pos_y_next = pos_y - POS_W'(1);
      DIR_LEFT:  pos_x_next = pos_x - POS_W'(1);
      default:   pos_x_next = pos_x;
    endcase
  end

  assign inside_next = interior(pos_x_next, pos_y_next, h_q);
  assign seen        = rd_data[col_q];

  assign in_ready = (state == ST_IDLE);
  assign rd_en    = (state == ST_IDLE) && in_valid && inside_now;
  assign rd_row   = row_sum[ROW_W-1:0];

  // Mark writes the row back with the bit set; clearing writes zeros
  always_comb begin
    wr_en   = 1'b0;
    wr_row  = row_q;
    wr_data = rd_data | (MAP_SIDE'(1) << col_q);
    case (state)
      ST_MARK: begin
        wr_en = 1'b1;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_row  = clr_row;
        wr_data = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign side        = {h_q, 1'b0} - (HW + 1)'(1);
  assign side_sq     = side * side;
  assign res.visited  = count;
  assign res.interior = CNT_W'(side_sq);

  assign stat.clearing  = (state == ST_CLEAR);
  assign stat.finishing = (state == ST_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      pos_x    <= '0;
      pos_y    <= '0;
      count    <= '0;
      hmax     <= '0;
      h_q      <= HW'(1);
      clr_row  <= '0;
      clr_last <= ROW_W'(MAP_SIDE - 1);
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            h_q   <= h_eff;
            dir_q <= direction;
            row_q <= row_sum[ROW_W-1:0];
            col_q <= col_sum[ROW_W-1:0];
            state <= inside_now ? ST_MARK : ST_FINISH;
          end
        end
        ST_MARK: begin
          if (!seen) begin
            count <= count + CNT_W'(1);
          end
          if (h_q > hmax) begin
            hmax <= h_q;
          end
          pos_x <= pos_x_next;
          pos_y <= pos_y_next;
          state <= inside_next ? ST_IDLE : ST_FINISH;
        end
        ST_FINISH: begin
          if (res_ready) begin
            pos_x    <= '0;
            pos_y    <= '0;
            count    <= '0;
            hmax     <= '0;
            // Only rows the walk could have touched need clearing
            clr_row  <= ROW_W'(MAX_HALF) - ROW_W'(hmax) + ROW_W'(1);
            clr_last <= ROW_W'(MAX_HALF) + ROW_W'(hmax) - ROW_W'(1);
            state    <= (hmax == '0) ? ST_IDLE : ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (clr_row == clr_last) begin
            state <= ST_IDLE;
          end else begin
            clr_row <= clr_row + ROW_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/random_walk_coverage_counter.sv]
// Top level of the random walk coverage counter: half_size register, output
// register and assertions. Uses rwcc_pkg, rwcc_walk_ctrl and rwcc_map_mem.
//
//  Channel  | Signals                                   | Transfer when
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid, in_ready, direction             | in_valid & in_ready
//  out      | out_valid, out_ready, visited_cells,      | out_valid & out_ready
//           | interior_cells                            |
//  cfg      | cfg_write, cfg_data (half_size)           | cfg_write
//
// Steps: a step inside the walk reads the bitmap row in ST_IDLE and writes it
// back in ST_MARK through the one memory port pair. A step that ends the walk
// then hands off the result in ST_FINISH and clears 2*hmax-1 bitmap rows, where
// hmax is the largest half size in force while cells were marked.
// Reset: a clearing pass over all 2*MAX_HALF+1 rows runs first, with in_ready
// low; configuration writes are taken throughout.
// Stalls: a result waits in the output register while the next walk goes on;
// only a second result stalls the controller until the first is taken.
module random_walk_coverage_counter
  import rwcc_pkg::*;
#(
  parameter int MAX_HALF = DEF_MAX_HALF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [HALF_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        direction,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  visited_cells,
  output logic [CNT_W-1:0]  interior_cells
);

  localparam int MAP_SIDE = 2 * MAX_HALF + 1;
  localparam int ROW_W    = $clog2(MAP_SIDE);

  logic [HALF_W-1:0]   half_size;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_row;
  logic [MAP_SIDE-1:0] rd_data;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_row;
  logic [MAP_SIDE-1:0] wr_data;
  logic                res_ready;
  ctrl_stat_t          stat;
  result_t             res;

  // Software must write half_size only between walks or when idle (unchecked)
  always_ff @(posedge clk) begin
    if (rst) begin
      half_size <= HALF_W'(1);
    end else if (cfg_write) begin
      half_size <= cfg_data;
    end
  end

  // Output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  rwcc_walk_ctrl #(
    .MAX_HALF (MAX_HALF),
    .MAP_SIDE (MAP_SIDE),
    .ROW_W    (ROW_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .half_size (half_size),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .direction (direction),
    .rd_en     (rd_en),
    .rd_row    (rd_row),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_row    (wr_row),
    .wr_data   (wr_data),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  // Read and write of one row never overlap: the next read is issued only
  // after the write-back cycle of the previous step has committed.
  rwcc_map_mem #(
    .ROWS (MAP_SIDE),
    .COLS (MAP_SIDE),
    .AW   (ROW_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_row  (wr_row),
    .wr_data (wr_data)
  );

  // Output register: load the finished walk, hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.finishing && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.finishing && res_ready) begin
      visited_cells  <= res.visited;
      interior_cells <= res.interior;
    end
  end

  // No input transfer while the bitmap is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !in_ready)
    else $error("input accepted during clearing pass");

  // Input transfers never come back to back
  a_two_cycle_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A new result appears only after the controller offered one
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(stat.finishing))
    else $error("result without a finished walk");

  // A waiting result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(visited_cells)
                                   && $stable(interior_cells)))
    else $error("pending result overwritten");

endmodule

[bench/random_walk_coverage_counter_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for random_walk_coverage_counter: directed walks, then random walks
// under several idle patterns, checked against a lattice walk model. Needs rwcc_pkg and the RTL.
module random_walk_coverage_counter_tb;
  import rwcc_pkg::*;

  localparam int MAP_HALF      = DEF_MAX_HALF;
  // Longest quiet time after the last result: hand-off plus a full clearing pass.
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_ITEMS   = 235;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [HALF_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        direction = DIR_UP;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  visited_cells;
  logic [CNT_W-1:0]  interior_cells;

  // Walk model state: position, marked cells, distinct count and the half size register.
  int                model_x;
  int                model_y;
  bit                seen_cells[int];
  logic [CNT_W-1:0]  model_count;
  logic [HALF_W-1:0] model_half;

  // Finished walks that the block still owes, oldest first.
  result_t           walk_results_q[$];

  int                error_count = 0;
  int                idle_pct = 0;   // chance that the sender holds off before a transfer
  int                stall_pct = 0;  // chance that the receiver drops out_ready in a cycle

  random_walk_coverage_counter u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .direction      (direction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .visited_cells  (visited_cells),
    .interior_cells (interior_cells)
  );

  always #5 clk = ~clk;

  // Receiver: one fresh draw per cycle, so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Effective half size: zero acts as one, anything past the map acts as the map edge.
  function automatic int eff_half();
    int h;
    h = int'(model_half);
    if (h < 1) h = 1;
    if (h > MAP_HALF) h = MAP_HALF;
    return h;
  endfunction

  function automatic bit in_interior(int h);
    return model_x < h && model_x > -h && model_y < h && model_y > -h;
  endfunction

  function automatic void restart_walk();
    model_x     = 0;
    model_y     = 0;
    model_count = '0;
    seen_cells.delete();
  endfunction

  // Advance the model by one accepted step; queue a result when the walk leaves the interior.
  // A walk caught outside after the half size shrank ends without marking or moving.
  function automatic void advance_walk_model(logic [1:0] dir);
    int      h;
    int      cell_idx;
    int      side;
    result_t done;
    h = eff_half();
    if (in_interior(h)) begin
      cell_idx = (model_x + MAP_HALF) * (2 * MAP_HALF + 1) + (model_y + MAP_HALF);
      if (!seen_cells.exists(cell_idx)) begin
        seen_cells[cell_idx] = 1'b1;
        model_count          = model_count + 1'b1;
      end
      case (dir)
        DIR_UP:    model_y++;
        DIR_RIGHT: model_x++;
        DIR_DOWN:  model_y--;
        default:   model_x--;
      endcase
    end
    if (!in_interior(h)) begin
      side          = 2 * h - 1;
      done.visited  = model_count;
      done.interior = CNT_W'(side * side);
      walk_results_q.push_back(done);
      restart_walk();
    end
  endfunction

  // Check every result transfer against the oldest owed walk, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (walk_results_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual visited %0d interior %0d",
                 $time, visited_cells, interior_cells);
        error_count++;
      end else begin
        want = walk_results_q.pop_front();
        if (visited_cells !== want.visited) begin
          $display("%0t: visited_cells mismatch: expected %0d, actual %0d",
                   $time, want.visited, visited_cells);
          error_count++;
        end
        if (interior_cells !== want.interior) begin
          $display("%0t: interior_cells mismatch: expected %0d, actual %0d",
                   $time, want.interior, interior_cells);
          error_count++;
        end
      end
    end
  end

  // Send one step. An idle gap, if drawn, drops valid first; otherwise valid stays high
  // straight from the previous transfer so it is never lowered and raised in one step.
  task automatic send_step(input logic [1:0] dir);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid  <= 1'b1;
    direction <= dir;
    do @(posedge clk); while (!in_ready);
    advance_walk_model(dir);
  endtask

  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    hold_off();
    while (walk_results_q.size() != 0) @(posedge clk);
  endtask

  // Bring the block to rest, then write half_size. The walk in progress, if any, keeps going
  // under the new value.
  task automatic write_half_size(input int value);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= HALF_W'(value);
    @(posedge clk);
    cfg_write  <= 1'b0;
    model_half  = HALF_W'(value);
    @(posedge clk);
  endtask

  // Reset value of half_size is one: every step marks the origin and ends the walk.
  task automatic test_reset_default();
    send_step(DIR_UP);
    send_step(DIR_RIGHT);
    send_step(DIR_DOWN);
    send_step(DIR_LEFT);
  endtask

  // Out-of-range register values: zero acts as one, 127 clamps to the map edge. Dropping from
  // 127 to zero mid-walk strands the walk outside, so the next step only closes it out and the
  // count exceeds the interior size.
  task automatic test_out_of_range_half();
    write_half_size(0);
    send_step(DIR_UP);
    send_step(DIR_LEFT);
    write_half_size(127);
    send_step(DIR_RIGHT);
    send_step(DIR_RIGHT);
    send_step(DIR_RIGHT);
    write_half_size(0);
    send_step(DIR_DOWN);
  endtask

  // Every direction, with revisits that must not count twice.
  task automatic test_all_directions();
    write_half_size(2);
    send_step(DIR_UP);
    send_step(DIR_RIGHT);
    send_step(DIR_DOWN);
    send_step(DIR_LEFT);
    send_step(DIR_UP);
    send_step(DIR_UP);
  endtask

  // Half size changed during a walk: grow it and walk through the old edge, then shrink it
  // with the walk far from the origin.
  task automatic test_resize_during_walk();
    write_half_size(2);
    send_step(DIR_RIGHT);
    write_half_size(5);
    repeat (6) send_step(DIR_LEFT);
    write_half_size(8);
    repeat (6) send_step(DIR_RIGHT);
    write_half_size(1);
    send_step(DIR_UP);
  endtask

  // One random phase. Large half sizes get a drift toward one side so the walk still reaches
  // the edge in a few hundred steps. Halfway through, hold the sender until every owed result
  // has come out.
  task automatic run_walk_phase(input int half, input int idle, input int stall);
    logic [1:0] lean;
    logic [1:0] dir;
    write_half_size(half);
    idle_pct  = idle;
    stall_pct = stall;
    lean      = 2'($urandom_range(0, 3));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (eff_half() > 16 && $urandom_range(0, 1) == 1)
        dir = lean;
      else
        dir = 2'($urandom_range(0, 3));
      send_step(dir);
      if (i == PHASE_ITEMS / 2) wait_results_drained();
    end
  endtask

  // Two phases per idle pattern: none, sender only, receiver only, then both lightly.
  // The half sizes take in the top of the register, the map edge and one past it.
  task automatic test_random_walks();
    int halves[8] = '{3, 5, 127, 2, 6, MAP_HALF, MAP_HALF + 1, 4};
    int idles[4]  = '{0, 45, 0, 7};
    int stalls[4] = '{0, 0, 45, 7};
    for (int p = 0; p < 8; p++) begin
      run_walk_phase(halves[p], idles[p / 2], stalls[p / 2]);
    end
  endtask

  initial begin
    model_half = HALF_W'(1);
    restart_walk();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default();
    test_out_of_range_half();
    test_all_directions();
    test_resize_during_walk();
    test_random_walks();

    // Drain what is owed, then give the block time to show any stray result.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with a full clearing pass per step.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
